/* sv/mvph_pkg.sv */
// Package for the MPEG video picture header scanner.
// Holds the shared item and result types and the start code constants.
// No dependencies.
`timescale 1ns / 1ps

package mvph_pkg;

  // Picture header capture length in bytes and counter width.
  localparam int unsigned HdrLen = 5;
  localparam int unsigned CntW   = 3;

  // Start code values.
  localparam logic [23:0] CodePrefix = 24'h000001;
  localparam logic [23:0] HistOnes   = 24'hFFFFFF;
  localparam logic [7:0]  PicCode    = 8'h00;
  localparam logic [7:0]  SeqCode    = 8'hB3;

  // Picture coding types that carry motion vector fields.
  localparam logic [2:0] TypeP = 3'd2;
  localparam logic [2:0] TypeB = 3'd3;

  // One input byte of a frame.
  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_of_frame;
  } item_t;

  // One header result.
  typedef struct packed {
    logic [9:0] temporal_ref;
    logic [2:0] coding_type;
    logic       fwd_full_pel;
    logic [2:0] fwd_f_code;
    logic       bwd_full_pel;
    logic [2:0] bwd_f_code;
    logic       sequence_start;
  } result_t;

endpackage

/* sv/mvph_in_reg.sv */
// Input register stage of the picture header scanner.
// Holds one accepted byte until the scan stage consumes it; uses mvph_pkg.
`timescale 1ns / 1ps

module mvph_in_reg
  import mvph_pkg::*;
(
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  in_valid_i,
  output logic  in_ready_o,
  input  item_t item_i,
  input  logic  pop_i,
  output logic  vld_o,
  output item_t item_o
);

  logic  vld_q, vld_d;
  item_t item_q;

  // A new request is taken when the stage is empty or drains this cycle.
  assign in_ready_o = !vld_q || pop_i;

  always_comb begin
    vld_d = vld_q;
    if (in_ready_o) begin
      vld_d = in_valid_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= vld_d;
    end
  end

  // Payload needs no reset.
  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      item_q <= item_i;
    end
  end

  assign vld_o  = vld_q;
  assign item_o = item_q;

endmodule

/* sv/mvph_scan.sv */
// Scan stage of the picture header scanner: start code search, header
// capture and held fields, all updated once per byte; uses mvph_pkg.
`timescale 1ns / 1ps

module mvph_scan
  import mvph_pkg::*;
(
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    vld_i,
  input  item_t   item_i,
  input  logic    out_busy_i,
  output logic    pop_o,
  output logic    res_vld_o,
  output result_t res_o
);

  typedef logic [HdrLen-1:0][7:0] cap_t;

  typedef struct packed {
    logic [9:0] tref;
    logic [2:0] ctype;
    logic [3:0] fwd;
    logic [3:0] bwd;
  } held_t;

  localparam logic [CntW-1:0] HdrLenC = CntW'(HdrLen);

  // Decode the captured header bytes into the held fields.
  function automatic held_t apply_hdr(cap_t cap, held_t h);
    held_t      r;
    logic [2:0] kind;
    r    = h;
    kind = cap[1][5:3];
    r.ctype = kind;
    r.tref  = {cap[0], cap[1][7:6]};
    if (kind == TypeP || kind == TypeB) begin
      r.fwd = {cap[3][2], cap[3][1:0], cap[4][7]};
    end
    if (kind == TypeB) begin
      r.bwd = {cap[4][6], cap[4][5:3]};
    end
    return r;
  endfunction

  logic [23:0]     hist_q, hist_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  cap_t            cap_q, cap_d;
  held_t           held_q, held_d;
  logic            seq_q, seq_d;

  // The stage moves on unless a frame end meets a full output register that is not being read.
  assign pop_o     = vld_i && (!item_i.last_of_frame || !out_busy_i);
  assign res_vld_o = pop_o && item_i.last_of_frame;

  // Next state and result for the byte in the input register.
  always_comb begin
    logic [CntW-1:0] cnt;
    cap_t            cap;
    held_t           held;
    logic            seq;
    logic [23:0]     hist;
    logic [7:0]      b;
    cnt  = cnt_q;
    cap  = cap_q;
    held = held_q;
    seq  = seq_q;
    hist = hist_q;
    b    = item_i.data_byte;
    if (cnt > HdrLenC) begin
      cnt = '0;
    end

    // Header capture takes the raw byte.
    if (cnt != '0) begin
      for (int i = 0; i < HdrLen; i++) begin
        if (HdrLenC - cnt == CntW'(i)) begin
          cap[i] = b;
        end
      end
      cnt = cnt - 1'b1;
      if (cnt == '0) begin
        held = apply_hdr(cap, held);
      end
    end

    // Start code detection; the history restarts after each code.
    if (hist == CodePrefix) begin
      if (b == PicCode) begin
        cap = '0;
        cnt = HdrLenC;
      end else if (b == SeqCode) begin
        seq = 1'b1;
      end
      hist = HistOnes;
    end else begin
      hist = {hist[15:0], b};
    end

    // A frame that ends during capture applies the partial header.
    if (item_i.last_of_frame && cnt != '0) begin
      held = apply_hdr(cap, held);
    end

    res_o.temporal_ref   = held.tref;
    res_o.coding_type    = held.ctype;
    res_o.fwd_full_pel   = held.fwd[3];
    res_o.fwd_f_code     = held.fwd[2:0];
    res_o.bwd_full_pel   = held.bwd[3];
    res_o.bwd_f_code     = held.bwd[2:0];
    res_o.sequence_start = seq;

    // Frame end clears all state.
    if (item_i.last_of_frame) begin
      hist = HistOnes;
      cnt  = '0;
      cap  = '0;
      held = '0;
      seq  = 1'b0;
    end

    hist_d = hist;
    cnt_d  = cnt;
    cap_d  = cap;
    held_d = held;
    seq_d  = seq;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hist_q <= HistOnes;
      cnt_q  <= '0;
      cap_q  <= '0;
      held_q <= '0;
      seq_q  <= 1'b0;
    end else if (pop_o) begin
      hist_q <= hist_d;
      cnt_q  <= cnt_d;
      cap_q  <= cap_d;
      held_q <= held_d;
      seq_q  <= seq_d;
    end
  end

endmodule

/* sv/mvph_out_reg.sv */
// Output register of the picture header scanner.
// Holds one header result until it is taken; uses mvph_pkg.
`timescale 1ns / 1ps

module mvph_out_reg
  import mvph_pkg::*;
(
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    load_i,
  input  result_t res_i,
  output logic    busy_o,
  output logic    out_valid_o,
  input  logic    out_ready_i,
  output result_t res_o
);

  logic    vld_q, vld_d;
  result_t res_q;

  // Full and not being taken this cycle.
  assign busy_o = vld_q && !out_ready_i;

  always_comb begin
    vld_d = vld_q;
    if (load_i) begin
      vld_d = 1'b1;
    end else if (out_ready_i) begin
      vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      res_q <= res_i;
    end
  end

  assign out_valid_o = vld_q;
  assign res_o       = res_q;

endmodule

/* sv/mpeg_video_picture_header_scan.sv */
// Top level of the MPEG video picture header scanner.
// Instantiates mvph_in_reg, mvph_scan and mvph_out_reg; uses mvph_pkg.
//
// The block takes one frame byte per cycle and returns one RFC 2250 video
// header result on the byte flagged as the last of its frame, none on other
// bytes. A byte passes an input register, then the scan stage, whose start
// code history, capture counter and held fields update once per byte, and
// a result is loaded into the output register as its byte leaves the scan
// stage. The sustained rate is one byte per cycle; it drops only when a
// frame end arrives while an earlier result still waits in the output
// register.
`timescale 1ns / 1ps

module mpeg_video_picture_header_scan
  import mvph_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [7:0] data_byte_i,
  input  logic       last_of_frame_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [9:0] temporal_ref_o,
  output logic [2:0] coding_type_o,
  output logic       fwd_full_pel_o,
  output logic [2:0] fwd_f_code_o,
  output logic       bwd_full_pel_o,
  output logic [2:0] bwd_f_code_o,
  output logic       sequence_start_o
);

  item_t   in_item, stage_item;
  logic    stage_vld, pop, res_vld, out_busy;
  result_t res, out_res;

  assign in_item.data_byte     = data_byte_i;
  assign in_item.last_of_frame = last_of_frame_i;

  // Input register.
  mvph_in_reg u_in_reg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .item_i     (in_item),
    .pop_i      (pop),
    .vld_o      (stage_vld),
    .item_o     (stage_item)
  );

  // Start code scan and header capture.
  mvph_scan u_scan (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .vld_i      (stage_vld),
    .item_i     (stage_item),
    .out_busy_i (out_busy),
    .pop_o      (pop),
    .res_vld_o  (res_vld),
    .res_o      (res)
  );

  // Result register.
  mvph_out_reg u_out_reg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (res_vld),
    .res_i       (res),
    .busy_o      (out_busy),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .res_o       (out_res)
  );

  assign temporal_ref_o   = out_res.temporal_ref;
  assign coding_type_o    = out_res.coding_type;
  assign fwd_full_pel_o   = out_res.fwd_full_pel;
  assign fwd_f_code_o     = out_res.fwd_f_code;
  assign bwd_full_pel_o   = out_res.bwd_full_pel;
  assign bwd_f_code_o     = out_res.bwd_f_code;
  assign sequence_start_o = out_res.sequence_start;

endmodule

/* tb/sv/tb.sv */
// Self-checking testbench for the MPEG video picture header scanner.
// Depends on mvph_pkg and mpeg_video_picture_header_scan; needs nothing else.
// Feeds frames of bytes through valid/ready and checks every header result.
`timescale 1ns / 1ps

module tb;
  import mvph_pkg::*;

  localparam int unsigned CycleLimit        = 200000;
  localparam int unsigned RandBytesPerPhase = 175;
  localparam int unsigned DrainCycles       = 8;
  localparam int unsigned MaxPrinted        = 40;

  logic       clk           = 1'b0;
  logic       rst_n         = 1'b0;
  logic       in_valid      = 1'b0;
  logic       in_ready;
  logic [7:0] data_byte     = 8'h00;
  logic       last_of_frame = 1'b0;
  logic       out_valid;
  logic       out_ready     = 1'b0;
  logic [9:0] temporal_ref;
  logic [2:0] coding_type;
  logic       fwd_full_pel;
  logic [2:0] fwd_f_code;
  logic       bwd_full_pel;
  logic [2:0] bwd_f_code;
  logic       sequence_start;

  // Requests waiting to be driven and header results still due.
  item_t       pending[$];
  result_t     headers_due[$];

  int unsigned send_idle_pct = 0;
  int unsigned sink_stall_pct = 0;
  int unsigned n_sent = 0;
  int unsigned n_taken = 0;
  int unsigned frames_sent = 0;
  int unsigned headers_seen = 0;
  int unsigned errors = 0;
  int unsigned cycles = 0;

  // Scanner state as predicted from the accepted bytes.
  logic [23:0] hdr_hist;
  int unsigned hdr_left;
  logic [7:0]  hdr_cap[HdrLen];
  logic [9:0]  hold_tref;
  logic [2:0]  hold_ctype;
  logic [3:0]  hold_fwd;
  logic [3:0]  hold_bwd;
  logic        hold_seq;

  mpeg_video_picture_header_scan dut (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .in_valid_i      (in_valid),
    .in_ready_o      (in_ready),
    .data_byte_i     (data_byte),
    .last_of_frame_i (last_of_frame),
    .out_valid_o     (out_valid),
    .out_ready_i     (out_ready),
    .temporal_ref_o  (temporal_ref),
    .coding_type_o   (coding_type),
    .fwd_full_pel_o  (fwd_full_pel),
    .fwd_f_code_o    (fwd_f_code),
    .bwd_full_pel_o  (bwd_full_pel),
    .bwd_f_code_o    (bwd_f_code),
    .sequence_start_o(sequence_start)
  );

  // Free-running clock with a 2 ns period.
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Cycle counter with a hard stop.
  always @(posedge clk) begin
    cycles++;
    if (cycles >= CycleLimit) begin
      $display("Timed out after %0d cycles with %0d headers still due.",
               cycles, headers_due.size());
      $display("RESULT: ERROR");
      $finish;
    end
  end

  task automatic report(input string msg);
    errors++;
    if (errors <= MaxPrinted) $display("MISMATCH cycle %0d: %s", cycles, msg);
  endtask

  // Return the scanner state to its power-up values.
  task automatic clear_scan();
    hdr_hist = HistOnes;
    hdr_left = 0;
    foreach (hdr_cap[i]) hdr_cap[i] = 8'h00;
    hold_tref = '0;
    hold_ctype = '0;
    hold_fwd = '0;
    hold_bwd = '0;
    hold_seq = 1'b0;
  endtask

  // Decode the captured picture header bytes into the held fields.
  task automatic apply_capture();
    logic [2:0] kind;
    kind = hdr_cap[1][5:3];
    hold_ctype = kind;
    hold_tref = {hdr_cap[0], hdr_cap[1][7:6]};
    if (kind == TypeP || kind == TypeB) hold_fwd = {hdr_cap[3][2:0], hdr_cap[4][7]};
    if (kind == TypeB) hold_bwd = hdr_cap[4][6:3];
  endtask

  // Advance the predicted scanner by one accepted byte.
  task automatic scan_byte(input logic [7:0] b, input logic last);
    result_t r;
    if (hdr_left != 0) begin
      hdr_cap[HdrLen - hdr_left] = b;
      hdr_left--;
      if (hdr_left == 0) apply_capture();
    end
    // A detected code resets the history so codes never share bytes.
    if (hdr_hist == CodePrefix) begin
      if (b == PicCode) begin
        foreach (hdr_cap[i]) hdr_cap[i] = 8'h00;
        hdr_left = HdrLen;
      end else if (b == SeqCode) begin
        hold_seq = 1'b1;
      end
      hdr_hist = HistOnes;
    end else begin
      hdr_hist = {hdr_hist[15:0], b};
    end
    // The frame end flushes a partial capture and emits the header.
    if (last) begin
      if (hdr_left != 0) apply_capture();
      r.temporal_ref   = hold_tref;
      r.coding_type    = hold_ctype;
      r.fwd_full_pel   = hold_fwd[3];
      r.fwd_f_code     = hold_fwd[2:0];
      r.bwd_full_pel   = hold_bwd[3];
      r.bwd_f_code     = hold_bwd[2:0];
      r.sequence_start = hold_seq;
      headers_due.push_back(r);
      clear_scan();
    end
  endtask

  task automatic push_byte(input logic [7:0] b, input logic last);
    item_t it;
    it.data_byte = b;
    it.last_of_frame = last;
    pending.push_back(it);
    if (last) frames_sent++;
  endtask

  // Queue a whole frame given as packed bytes, first byte most significant.
  task automatic push_packed(input logic [103:0] v, input int n);
    for (int i = 0; i < n; i++) push_byte(v[8 * (n - 1 - i) +: 8], i == n - 1);
  endtask

  // Request driver: a new byte only once the previous one was taken.
  always @(negedge clk) begin : drive_bytes
    item_t nxt;
    if (rst_n && n_sent == n_taken) begin
      if (pending.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        nxt = pending.pop_front();
        data_byte <= nxt.data_byte;
        last_of_frame <= nxt.last_of_frame;
        in_valid <= 1'b1;
        n_sent++;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Result side back-pressure.
  always @(negedge clk) begin
    out_ready <= ($urandom_range(99) >= sink_stall_pct);
  end

  // Monitor: predict on accepted bytes, check accepted results.
  always @(posedge clk) begin : watch_ports
    result_t want;
    if (rst_n) begin
      if (in_valid && in_ready) begin
        scan_byte(data_byte, last_of_frame);
        n_taken++;
      end
      if (out_valid && out_ready) begin
        headers_seen++;
        if (headers_due.size() == 0) begin
          report($sformatf("header with none due, temporal_ref %0h", temporal_ref));
        end else begin
          want = headers_due.pop_front();
          if (temporal_ref !== want.temporal_ref)
            report($sformatf("temporal_ref %0h, want %0h", temporal_ref, want.temporal_ref));
          if (coding_type !== want.coding_type)
            report($sformatf("coding_type %0d, want %0d", coding_type, want.coding_type));
          if (fwd_full_pel !== want.fwd_full_pel)
            report($sformatf("fwd_full_pel %0b, want %0b", fwd_full_pel, want.fwd_full_pel));
          if (fwd_f_code !== want.fwd_f_code)
            report($sformatf("fwd_f_code %0d, want %0d", fwd_f_code, want.fwd_f_code));
          if (bwd_full_pel !== want.bwd_full_pel)
            report($sformatf("bwd_full_pel %0b, want %0b", bwd_full_pel, want.bwd_full_pel));
          if (bwd_f_code !== want.bwd_f_code)
            report($sformatf("bwd_f_code %0d, want %0d", bwd_f_code, want.bwd_f_code));
          if (sequence_start !== want.sequence_start)
            report($sformatf("sequence_start %0b, want %0b", sequence_start,
                             want.sequence_start));
        end
      end
    end
  end

  // Stimulus: four pacing phases, directed frames first, then random frames.
  initial begin
    int unsigned send_pct[4];
    int unsigned sink_pct[4];
    logic [7:0]  fbytes[$];
    logic [7:0]  b1;
    logic [2:0]  kind;
    int unsigned phase_bytes;
    int unsigned seg;
    int unsigned cut;

    send_pct = '{0, 61, 0, 38};
    sink_pct = '{0, 0, 61, 38};
    clear_scan();
    repeat (9) @(negedge clk);
    rst_n = 1'b1;

    for (int p = 0; p < 4; p++) begin
      send_idle_pct = send_pct[p];
      sink_stall_pct = sink_pct[p];

      if (p == 0) begin
        // Sequence code, then a B picture header of all-ones fields ending the frame.
        push_packed(104'h000001B3_00000100_FFDFFFFFFF, 13);
        // Picture code on the very last byte of the frame.
        push_packed(104'h00000100, 4);
        // Picture code inside the capture window restarts it; frame ends mid-capture.
        push_packed(104'h000001_00000001_005A, 9);
      end

      phase_bytes = 0;
      while (phase_bytes < RandBytesPerPhase) begin
        fbytes.delete();
        repeat ($urandom_range(1, 4)) begin
          seg = $urandom_range(9);
          if (seg < 4) begin
            // Picture header, mostly of the I, P and B types.
            kind = $urandom_range(1) ? 3'($urandom_range(7)) : 3'($urandom_range(1, 3));
            b1 = 8'($urandom);
            b1[5:3] = kind;
            fbytes.push_back(8'h00);
            fbytes.push_back(8'h00);
            fbytes.push_back(8'h01);
            fbytes.push_back(PicCode);
            fbytes.push_back(8'($urandom));
            fbytes.push_back(b1);
            fbytes.push_back(8'($urandom));
            fbytes.push_back(8'($urandom));
            fbytes.push_back(8'($urandom));
          end else if (seg < 6) begin
            // Sequence header or some other start code.
            fbytes.push_back(8'h00);
            fbytes.push_back(8'h00);
            fbytes.push_back(8'h01);
            fbytes.push_back(seg == 4 ? SeqCode : 8'($urandom));
          end else begin
            // Noise leaning on zeros and ones to form partial prefixes.
            repeat ($urandom_range(1, 4)) begin
              case ($urandom_range(3))
                0: fbytes.push_back(8'h00);
                1: fbytes.push_back(8'h01);
                default: fbytes.push_back(8'($urandom));
              endcase
            end
          end
        end
        // Some frames end early, often in the middle of a capture.
        if ($urandom_range(3) == 0) begin
          cut = $urandom_range(1, fbytes.size());
          while (fbytes.size() > cut) void'(fbytes.pop_back());
        end
        foreach (fbytes[i]) push_byte(fbytes[i], i == fbytes.size() - 1);
        phase_bytes += fbytes.size();
      end

      while (pending.size() != 0 || n_sent != n_taken || headers_due.size() != 0)
        @(posedge clk);
    end

    repeat (DrainCycles) @(posedge clk);
    if (headers_due.size() != 0)
      report($sformatf("%0d headers never arrived", headers_due.size()));

    $display("Scanned %0d bytes in %0d frames and checked %0d headers,", n_taken,
             frames_sent, headers_seen);
    $display("with free flow, sender gaps, receiver stalls and both together.");
    if (errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("%0d mismatches found.", errors);
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
